// File: hdl/chacha_grid_block_mixer_core_assert.svh
// Assertion macros used by the block mixer port checker.
`ifndef CHACHA_GRID_BLOCK_MIXER_CORE_ASSERT_SVH
`define CHACHA_GRID_BLOCK_MIXER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CGBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("block mixer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CGBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("block mixer check failed");

`endif

// File: hdl/cgbm_pkg.sv
// Types and constants for the ChaCha grid block mixer.
package cgbm_pkg;

    localparam int GRID_WORDS    = 256;
    localparam int BEAT_WORDS    = 4;
    localparam int LANE_WORDS    = 16;
    localparam int LOAD_BEATS    = GRID_WORDS / BEAT_WORDS;
    localparam int DOUBLE_ROUNDS = 10;

    typedef logic [31:0] word_t;
    typedef word_t [LANE_WORDS-1:0] lane_t;
    typedef word_t [BEAT_WORDS-1:0] beat_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_ROUND,
        ST_STORE,
        ST_EMIT
    } state_t;

    // step of the shared round unit: column or diagonal round, first or second half
    typedef struct packed {
        logic diag;
        logic half;
    } rnd_ctl_t;

endpackage

// File: hdl/cgbm_round.sv
// Shared round unit: half of four parallel quarter rounds on a 16-word lane.
module cgbm_round
    import cgbm_pkg::*;
(
    input  lane_t    v,
    input  rnd_ctl_t ctl,
    output lane_t    v_next
);

    word_t a_s [4];
    word_t b_s [4];
    word_t c_s [4];
    word_t d_s [4];

    // word of quarter q at grid row r; diagonal rounds shift the column by the row
    function automatic logic [3:0] qix(input logic [1:0] q, input logic [1:0] r,
                                       input logic diag);
        logic [1:0] col;
        col = diag ? (q + r) : q;
        return {r, col};
    endfunction

    function automatic word_t rot_d(input word_t x, input logic half);
        return half ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
    endfunction

    function automatic word_t rot_b(input word_t x, input logic half);
        return half ? {x[24:0], x[31:25]} : {x[19:0], x[31:20]};
    endfunction

    always_comb
    begin
        v_next = v;
        for (int q = 0; q < 4; q++)
        begin
            a_s[q] = v[qix(2'(q), 2'd0, ctl.diag)] + v[qix(2'(q), 2'd1, ctl.diag)];
            d_s[q] = rot_d(v[qix(2'(q), 2'd3, ctl.diag)] ^ a_s[q], ctl.half);
            c_s[q] = v[qix(2'(q), 2'd2, ctl.diag)] + d_s[q];
            b_s[q] = rot_b(v[qix(2'(q), 2'd1, ctl.diag)] ^ c_s[q], ctl.half);
            v_next[qix(2'(q), 2'd0, ctl.diag)] = a_s[q];
            v_next[qix(2'(q), 2'd1, ctl.diag)] = b_s[q];
            v_next[qix(2'(q), 2'd2, ctl.diag)] = c_s[q];
            v_next[qix(2'(q), 2'd3, ctl.diag)] = d_s[q];
        end
    end

endmodule

// File: hdl/chacha_grid_block_mixer_core.sv
// Top level of the ChaCha grid block mixer: block store, sequencer and lane register.
//
// Input channel (in_valid/in_ready, word0..word3): 64 beats of four words make a
// 256-word block, word0 at the lowest index. in_ready is high only while loading.
// After the 64th beat the block is mixed as a 16 x 16 grid: ChaCha20 permutation
// (ten double rounds, no feed-forward) on every row, then on every column.
// Output channel (out_valid/out_ready, out0..out3, final_res): 64 beats of four
// mixed words in rising word order; final_res marks the 64th beat.
// Sequence: each lane is read from the block store into the lane register (fetch),
// mixed in place (round) and written back (store); a row lane uses four store
// entries, a column lane one word of each of sixteen entries. Mixing time is set
// by the single round unit, which runs each double round as a column and a
// diagonal round of two halves each, and by the one-entry-per-cycle read and
// write ports of the block store.
// Output stalls hold the current beat; the next store read waits for out_ready.
// No new block is taken until the last result beat is accepted.
// Reset drops any partial block and returns to loading; the store is not cleared.
module chacha_grid_block_mixer_core
    import cgbm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  word_t word0,
    input  word_t word1,
    input  word_t word2,
    input  word_t word3,
    output logic  out_valid,
    input  logic  out_ready,
    output word_t out0,
    output word_t out1,
    output word_t out2,
    output word_t out3,
    output logic  final_res
);

    state_t      state_reg, state_next;
    logic [5:0]  load_cnt_reg, load_cnt_next;
    logic [3:0]  lane_reg, lane_next;
    logic        pass_reg, pass_next;      // 0: rows, 1: columns
    logic [3:0]  dround_reg, dround_next;
    logic [1:0]  step_reg, step_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        rd_pend_reg, rd_pend_next;
    logic [3:0]  rd_idx_reg, rd_idx_next;
    logic [6:0]  emit_cnt_reg, emit_cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic        final_reg, final_next;
    lane_t       v_reg, v_next;
    lane_t       v_mix;
    rnd_ctl_t    rnd_ctl;

    beat_t       mem [LOAD_BEATS];
    beat_t       rd_data_reg;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [3:0]  wr_mask;
    beat_t       wr_data;
    logic        rd_en;
    logic        fetch_rd;
    logic        emit_rd;
    logic [5:0]  rd_addr;

    logic [4:0]  nwords;
    logic [3:0]  last_idx;
    logic        fetch_done;
    logic        round_done;
    logic        store_last;
    logic        emit_done;

    assign nwords     = pass_reg ? 5'd16 : 5'd4;
    assign last_idx   = pass_reg ? 4'd15 : 4'd3;
    assign fetch_done = rd_pend_reg && (rd_idx_reg == last_idx);
    assign round_done = (dround_reg == 4'(DOUBLE_ROUNDS - 1)) && (step_reg == 2'd3);
    assign store_last = cnt_reg[3:0] == last_idx;
    assign emit_done  = (emit_cnt_reg == 7'(LOAD_BEATS)) && (!out_valid_reg || out_ready);

    assign rnd_ctl.diag = step_reg[1];
    assign rnd_ctl.half = step_reg[0];

    cgbm_round u_round (
        .v      (v_reg),
        .ctl    (rnd_ctl),
        .v_next (v_mix)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && load_cnt_reg == 6'(LOAD_BEATS - 1))
                    state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                if (fetch_done)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_done)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                if (store_last)
                    state_next = (lane_reg == 4'd15 && pass_reg) ? ST_EMIT : ST_FETCH;
            end
            ST_EMIT:
            begin
                if (emit_done)
                    state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // store port control
    always_comb
    begin
        in_ready = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = load_cnt_reg;
        wr_mask  = 4'b1111;
        wr_data  = {word3, word2, word1, word0};
        fetch_rd = 1'b0;
        emit_rd  = 1'b0;
        rd_addr  = emit_cnt_reg[5:0];
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                wr_en    = in_valid;
            end
            ST_FETCH:
            begin
                fetch_rd = cnt_reg < nwords;
                rd_addr  = pass_reg ? {cnt_reg[3:0], lane_reg[3:2]} : {lane_reg, cnt_reg[1:0]};
            end
            ST_STORE:
            begin
                wr_en   = 1'b1;
                wr_addr = pass_reg ? {cnt_reg[3:0], lane_reg[3:2]} : {lane_reg, cnt_reg[1:0]};
                wr_mask = pass_reg ? (4'b0001 << lane_reg[1:0]) : 4'b1111;
                for (int k = 0; k < BEAT_WORDS; k++)
                    wr_data[k] = pass_reg ? v_reg[cnt_reg[3:0]] : v_reg[{cnt_reg[1:0], 2'(k)}];
            end
            ST_EMIT:
            begin
                emit_rd = (emit_cnt_reg < 7'(LOAD_BEATS)) && (!out_valid_reg || out_ready);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign rd_en = fetch_rd || emit_rd;

    // counters and lane register
    always_comb
    begin
        load_cnt_next  = load_cnt_reg;
        lane_next      = lane_reg;
        pass_next      = pass_reg;
        dround_next    = dround_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        v_next         = v_reg;
        rd_pend_next   = fetch_rd;
        rd_idx_next    = cnt_reg[3:0];
        out_valid_next = emit_rd ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        final_next     = emit_rd ? (emit_cnt_reg == 7'(LOAD_BEATS - 1)) : final_reg;

        if (in_ready && in_valid)
            load_cnt_next = load_cnt_reg + 6'd1;

        case (state_reg)
            ST_FETCH:
            begin
                if (fetch_rd)
                    cnt_next = cnt_reg + 5'd1;
                if (fetch_done)
                    cnt_next = 5'd0;
                if (rd_pend_reg)
                begin
                    if (pass_reg)
                        v_next[rd_idx_reg] = rd_data_reg[lane_reg[1:0]];
                    else
                        for (int k = 0; k < BEAT_WORDS; k++)
                            v_next[{rd_idx_reg[1:0], 2'(k)}] = rd_data_reg[k];
                end
            end
            ST_ROUND:
            begin
                v_next    = v_mix;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                    dround_next = (dround_reg == 4'(DOUBLE_ROUNDS - 1)) ? 4'd0
                                                                         : dround_reg + 4'd1;
            end
            ST_STORE:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (store_last)
                begin
                    cnt_next  = 5'd0;
                    lane_next = lane_reg + 4'd1;
                    if (lane_reg == 4'd15)
                        pass_next = ~pass_reg;
                end
            end
            ST_EMIT:
            begin
                if (emit_rd)
                    emit_cnt_next = emit_cnt_reg + 7'd1;
                if (emit_done)
                    emit_cnt_next = 7'd0;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            load_cnt_reg  <= '0;
            lane_reg      <= '0;
            pass_reg      <= 1'b0;
            dround_reg    <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            lane_reg      <= lane_next;
            pass_reg      <= pass_next;
            dround_reg    <= dround_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            rd_idx_reg    <= rd_idx_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
            final_reg     <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    // block store: 64 entries of four words, per-word write enables
    always_ff @(posedge clk)
    begin
        if (wr_en)
            for (int k = 0; k < BEAT_WORDS; k++)
                if (wr_mask[k])
                    mem[wr_addr][k] <= wr_data[k];
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // result beat is the store read register itself
    assign out_valid = out_valid_reg;
    assign out0      = rd_data_reg[0];
    assign out1      = rd_data_reg[1];
    assign out2      = rd_data_reg[2];
    assign out3      = rd_data_reg[3];
    assign final_res = out_valid_reg && final_reg;

endmodule

// File: hdl/cgbm_port_checker.sv
// Port-level checks for the block mixer, bound to the top level.
`include "chacha_grid_block_mixer_core_assert.svh"

module cgbm_port_checker
    import cgbm_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input word_t word0,
    input word_t word1,
    input word_t word2,
    input word_t word3,
    input logic  out_valid,
    input logic  out_ready,
    input word_t out0,
    input word_t out1,
    input word_t out2,
    input word_t out3,
    input logic  final_res
);

    logic in_seen;
    assign in_seen = in_valid || (word0 == word1 && word2 == word3) || 1'b1;

    // a stalled result beat holds
    `CGBM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out0) && $stable(out1) && $stable(out2) && $stable(out3) && $stable(final_res))

    // no input is taken while results of the previous block are pending
    `CGBM_ASSERT_NOW(a_no_overlap, clk, rst_n, in_ready && in_seen, !out_valid)

    // the last flag only rides on a valid beat
    `CGBM_ASSERT_NOW(a_final_valid, clk, rst_n, final_res, out_valid)

    // nothing follows the last beat of a block
    `CGBM_ASSERT_NEXT(a_final_ends, clk, rst_n, out_valid && out_ready && final_res, !out_valid)

endmodule

bind chacha_grid_block_mixer_core cgbm_port_checker u_port_checker (.*);
